### rtl/jtum_pkg.sv
// shared types and constants for the job trace utilisation monitor
package jtum_pkg;

    localparam logic [1:0]  MODE_RECORD = 2'd0;
    localparam logic [1:0]  MODE_QUERY  = 2'd1;
    localparam logic [1:0]  MODE_CLEAR  = 2'd2;

    localparam logic [31:0] DUR_CAP     = 32'hffff_fffe;
    localparam logic [16:0] Q16_ONE     = 17'd65536;
    localparam int          Q_STEPS     = 16;
    localparam int          QCNT_W      = 4;

    localparam int          IN_DATA_W   = 152;
    localparam int          IN_USER_W   = 2;
    localparam int          OUT_DATA_W  = 184;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_OLD,
        ST_UPDATE,
        ST_RD_OLDEST,
        ST_SPAN,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        stolen;
        logic [15:0] prio;
        logic [31:0] dur;
        logic [63:0] start;
    } t_slot;

    typedef struct packed {
        logic in_ready;
        logic rd_cur;
        logic do_update;
        logic span_calc;
        logic util_chk;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic is_record;
        logic need_div;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

### rtl/jtum_ctrl.sv
// sequencing state machine for the utilisation monitor
module jtum_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jtum_pkg::t_stat i_stat,
    output jtum_pkg::t_cmd  o_cmd
);
    import jtum_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_stat.in_valid) n_state = ST_RD_OLD;
            end
            ST_RD_OLD: begin
                n_state = i_stat.is_record ? ST_UPDATE : ST_RD_OLDEST;
            end
            ST_UPDATE:    n_state = ST_RD_OLDEST;
            ST_RD_OLDEST: n_state = ST_SPAN;
            ST_SPAN:      n_state = ST_CHECK;
            ST_CHECK: begin
                n_state = i_stat.need_div ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (i_stat.div_last) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:      o_cmd.in_ready  = 1'b1;
            ST_RD_OLD:    o_cmd.rd_cur    = 1'b1;
            ST_UPDATE:    o_cmd.do_update = 1'b1;
            ST_RD_OLDEST: o_cmd.rd_cur    = 1'b1;
            ST_SPAN:      o_cmd.span_calc = 1'b1;
            ST_CHECK:     o_cmd.util_chk  = 1'b1;
            ST_DIV:       o_cmd.div_step  = 1'b1;
            ST_OUT:       o_cmd.load_out  = i_stat.out_free;
            default:      o_cmd = '0;
        endcase
    end

endmodule

### rtl/jtum_dpath.sv
// ring memory, statistics, span logic and restoring divider
module jtum_dpath #(
    parameter int RING_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  jtum_pkg::t_cmd                  i_cmd,
    output jtum_pkg::t_stat                 o_stat,
    input  logic                            i_s_tvalid,
    input  logic [jtum_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [jtum_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [jtum_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import jtum_pkg::*;

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int BUSY_W = AW + 32;

    // captured transaction
    logic [1:0]  r_mode;
    logic [63:0] r_start;
    logic [63:0] r_end;
    logic [15:0] r_prio;
    logic        r_stolen;

    t_slot r_ring [RING_DEPTH];
    t_slot r_rd_data;

    logic [AW-1:0]     r_wp;
    logic              r_wrapped;
    logic [63:0]       r_jobs;
    logic [63:0]       r_total;
    logic [31:0]       r_max;
    logic [BUSY_W-1:0] r_busy;
    logic [63:0]       r_span_end;
    logic [63:0]       r_slot0_start;
    logic [31:0]       r_dur;

    logic [63:0]       r_span;
    logic              r_span_ok;
    logic [63:0]       r_rem;
    logic [16:0]       r_quo;
    logic [QCNT_W-1:0] r_cnt;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic        accept;
    logic [63:0] dur_diff;
    logic [31:0] n_dur;
    logic [31:0] old_dur;
    logic        full;
    logic [63:0] span_base;
    logic [64:0] span_diff;
    logic [64:0] rem_dbl;
    logic [64:0] rem_sub;
    logic        out_free;
    logic        need_div;

    assign accept   = i_cmd.in_ready && i_s_tvalid;
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        dur_diff = r_end - r_start;
        if (r_end <= r_start) begin
            n_dur = '0;
        end else if ((|dur_diff[63:32]) || (dur_diff[31:0] > DUR_CAP)) begin
            n_dur = DUR_CAP;
        end else begin
            n_dur = dur_diff[31:0];
        end
    end

    // a slot's old duration counts only once the slot is written, tracked by the wrap flag
    assign old_dur    = r_wrapped ? r_rd_data.dur : 32'd0;
    assign full       = r_jobs >= 64'(RING_DEPTH);
    assign span_base  = full ? r_rd_data.start : r_slot0_start;
    assign span_diff  = {1'b0, r_span_end} - {1'b0, span_base};
    assign rem_dbl    = {r_rem, 1'b0};
    assign rem_sub    = rem_dbl - {1'b0, r_span};
    assign need_div   = r_span_ok && (64'(r_busy) < r_span);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_s_tuser;
            r_start  <= i_s_tdata[63:0];
            r_end    <= i_s_tdata[127:64];
            r_prio   <= i_s_tdata[143:128];
            r_stolen <= i_s_tdata[144];
        end
        if (i_cmd.rd_cur) begin
            r_rd_data <= r_ring[r_wp];
            r_dur     <= n_dur;
        end
        if (i_cmd.do_update) begin
            r_ring[r_wp] <= '{stolen: r_stolen, prio: r_prio, dur: r_dur, start: r_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp          <= '0;
            r_wrapped     <= 1'b0;
            r_jobs        <= '0;
            r_total       <= '0;
            r_max         <= '0;
            r_busy        <= '0;
            r_span_end    <= '0;
            r_slot0_start <= '0;
        end else begin
            if (i_cmd.do_update) begin
                r_wp       <= r_wp + AW'(1);
                r_busy     <= r_busy - BUSY_W'(old_dur) + BUSY_W'(r_dur);
                r_jobs     <= r_jobs + 64'd1;
                r_total    <= r_total + 64'(r_dur);
                r_span_end <= r_start + 64'(r_dur);
                if (r_dur > r_max) r_max <= r_dur;
                if (r_wp == AW'(RING_DEPTH - 1)) r_wrapped <= 1'b1;
                if (r_wp == '0) r_slot0_start <= r_start;
            end
            if (i_cmd.span_calc && (r_mode == MODE_CLEAR)) begin
                r_max <= '0;
            end
        end
    end

    // span, saturation check, 16-step restoring divide and output load
    always_ff @(posedge i_clk) begin
        if (i_cmd.span_calc) begin
            r_span    <= span_diff[63:0];
            r_span_ok <= (r_jobs != 64'd0) && !span_diff[64] && (span_diff[63:0] != 64'd0);
        end
        if (i_cmd.util_chk) begin
            r_cnt <= '0;
            r_rem <= 64'(r_busy);
            if (!r_span_ok) begin
                r_quo <= '0;
            end else if (64'(r_busy) >= r_span) begin
                r_quo <= Q16_ONE;
            end else begin
                r_quo <= '0;
            end
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + QCNT_W'(1);
            if (!rem_sub[64]) begin
                r_rem <= rem_sub[63:0];
                r_quo <= {r_quo[15:0], 1'b1};
            end else begin
                r_rem <= rem_dbl[63:0];
                r_quo <= {r_quo[15:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            r_out_data <= {7'd0, r_jobs, r_total, r_max, r_quo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.in_valid  = i_s_tvalid;
    assign o_stat.is_record = (r_mode == MODE_RECORD);
    assign o_stat.need_div  = need_div;
    assign o_stat.div_last  = (r_cnt == QCNT_W'(Q_STEPS - 1));
    assign o_stat.out_free  = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

### rtl/job_trace_utilisation_monitor.sv
// top level of the job trace utilisation monitor
//
//  channel  dir  signals                      fields (lsb first)
//  s        in   i_s_tvalid o_s_tready        tuser: mode; tdata: job_start, job_end,
//                i_s_tdata i_s_tuser                 priority_req, was_stolen
//  m        out  o_m_tvalid i_m_tready        tdata: utilisation_q16, longest_dur,
//                o_m_tdata                           total_dur, job_total
//
// a transaction steps through a read of the overwritten slot, an update (record only),
// a read of the oldest slot, span, check, the 16-step restoring divide (skipped when the
// result is zero or saturated) and output; the next is taken only after output.
// reset clears all counters at once; ring slot data is used only once written.
// a finished result waits in the output register while the next transaction is taken;
// only a result that finds the previous one still untaken holds the sequencer.
module job_trace_utilisation_monitor #(
    parameter int RING_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // job_start[63:0], job_end[127:64], priority_req[143:128], was_stolen[144], zero fill
    input  logic [jtum_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // mode[1:0]
    input  logic [jtum_pkg::IN_USER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // utilisation_q16[16:0], longest_dur[48:17], total_dur[112:49], job_total[176:113]
    output logic [jtum_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import jtum_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    jtum_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    jtum_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    assign o_s_tready = w_cmd.in_ready;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken again right after a transaction");

    a_util_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[16:0] <= Q16_ONE))
        else $error("utilisation above one");

    a_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.in_ready, w_cmd.do_update, w_cmd.span_calc, w_cmd.util_chk,
                  w_cmd.div_step, w_cmd.load_out}))
        else $error("several datapath steps at once");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !w_cmd.load_out)
        else $error("result loaded over an untaken one");

endmodule
